// ===== hw/rtl/rcts_pkg.sv =====
package rcts_pkg;

   localparam int unsigned PERIOD_W = 24;
   localparam int unsigned CHARGE_W = 20;
   localparam int unsigned DEB_W    = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned STABLE_W   = 8;

   localparam int unsigned DISCHARGE_TICKS_DEF = 50;
   localparam int unsigned COUNT_MAX_DEF       = 255;

   localparam logic [PERIOD_W-1:0] STARTUP_DELAY_RST = 24'd2000000;
   localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST   = 24'd100000;
   localparam logic [CHARGE_W-1:0] TIMEOUT_RST       = 20'd100000;
   localparam logic [CHARGE_W-1:0] MMWAVE_MIN_RST    = 20'd1000;
   localparam logic [CHARGE_W-1:0] MMWAVE_MAX_RST    = 20'd5000;
   localparam logic [CHARGE_W-1:0] VIBRA_MIN_RST     = 20'd5001;
   localparam logic [CHARGE_W-1:0] VIBRA_MAX_RST     = 20'd20000;
   localparam logic [DEB_W-1:0]    DEBOUNCE_RST      = 8'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STARTUP_DELAY = 3'd0,
      REG_POLL_PERIOD   = 3'd1,
      REG_TIMEOUT       = 3'd2,
      REG_MMWAVE_MIN    = 3'd3,
      REG_MMWAVE_MAX    = 3'd4,
      REG_VIBRA_MIN     = 3'd5,
      REG_VIBRA_MAX     = 3'd6,
      REG_DEBOUNCE      = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      CLS_NONE    = 2'd0,
      CLS_MMWAVE  = 2'd1,
      CLS_VIBRA   = 2'd2,
      CLS_UNKNOWN = 2'd3
   } class_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] startup_delay;
      logic [PERIOD_W-1:0] poll_period;
      logic [CHARGE_W-1:0] timeout;
      logic [CHARGE_W-1:0] mmwave_min;
      logic [CHARGE_W-1:0] mmwave_max;
      logic [CHARGE_W-1:0] vibra_min;
      logic [CHARGE_W-1:0] vibra_max;
      logic [DEB_W-1:0]    debounce_needed;
   } cfg_type;

   typedef struct packed {
      logic                drive;
      logic                done;
      logic                tmo;
      logic [CHARGE_W-1:0] count;
   } meas_type;

   typedef struct packed {
      logic [CHARGE_W-1:0] measured;
      class_type           det_class;
      logic [STABLE_W-1:0] stable;
      class_type           cur_state;
      logic                changed;
   } deb_res_type;

endpackage

// ===== hw/rtl/rc_charge_time_slot_classifier_top.sv =====
// Channel  Ports                       Direction  Moves
// req      req_valid/req_ready         in         one microsecond tick with pin level
// rsp      rsp_valid/rsp_ready         out        one status word per tick
// csr      csr_wr_en/csr_index/data    in         register write, no read-back
//
// One transaction per cycle unless rsp stalls. A req passes the input register,
// then the result register, before rsp valid. The tick counters advance only
// when a transaction moves into the result register. A stalled rsp holds the
// result and leaves room for one more transaction in the input register.
// Synchronous reset clears all control state and loads the register defaults.
module rc_charge_time_slot_classifier_top
   import rcts_pkg::*;
#(
   parameter int unsigned DISCHARGE_TICKS = DISCHARGE_TICKS_DEF,
   parameter int unsigned COUNT_MAX       = COUNT_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_sense_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_drive_low,
   output logic                  rsp_sample_done,
   output logic                  rsp_timed_out,
   output logic [CHARGE_W-1:0]   rsp_charge_ticks,
   output logic [1:0]            rsp_detected_class,
   output logic [STABLE_W-1:0]   rsp_stable_count,
   output logic [1:0]            rsp_current_state,
   output logic                  rsp_state_changed,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type     cfg;
   meas_type    meas;
   deb_res_type res;

   logic in_valid_ff, in_level_ff;
   logic out_valid_ff;
   logic advance;

   logic                drive_ff, done_ff, tmo_ff, changed_ff;
   logic [CHARGE_W-1:0] measured_ff;
   class_type           class_ff, state_ff;
   logic [STABLE_W-1:0] stable_ff;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   rcts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   rcts_poll #(
      .DISCHARGE_TICKS (DISCHARGE_TICKS)
   ) u_poll (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .level   (in_level_ff),
      .cfg     (cfg),
      .meas    (meas)
   );

   rcts_debounce #(
      .COUNT_MAX (COUNT_MAX)
   ) u_debounce (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .meas    (meas),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_level_ff <= req_sense_level;
      end
      if (advance) begin
         drive_ff    <= meas.drive;
         done_ff     <= meas.done;
         tmo_ff      <= meas.tmo;
         measured_ff <= res.measured;
         class_ff    <= res.det_class;
         stable_ff   <= res.stable;
         state_ff    <= res.cur_state;
         changed_ff  <= res.changed;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_drive_low      = drive_ff;
   assign rsp_sample_done    = done_ff;
   assign rsp_timed_out      = tmo_ff;
   assign rsp_charge_ticks   = measured_ff;
   assign rsp_detected_class = class_ff;
   assign rsp_stable_count   = stable_ff;
   assign rsp_current_state  = state_ff;
   assign rsp_state_changed  = changed_ff;

   a_done_not_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_sample_done && rsp_drive_low))
      else $error("measurement finished on a discharge tick");

   a_tmo_class_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_sample_done && rsp_detected_class == CLS_NONE)
      else $error("timeout without finished measurement of class none");

   a_change_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_state_changed |->
         rsp_sample_done && rsp_current_state == rsp_detected_class)
      else $error("state change not tied to a finished measurement");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

// ===== hw/rtl/rcts_csr.sv =====
module rcts_csr
   import rcts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_index))
            REG_STARTUP_DELAY: cfg_in.startup_delay   = csr_wr_data[PERIOD_W-1:0];
            REG_POLL_PERIOD:   cfg_in.poll_period     = csr_wr_data[PERIOD_W-1:0];
            REG_TIMEOUT:       cfg_in.timeout         = csr_wr_data[CHARGE_W-1:0];
            REG_MMWAVE_MIN:    cfg_in.mmwave_min      = csr_wr_data[CHARGE_W-1:0];
            REG_MMWAVE_MAX:    cfg_in.mmwave_max      = csr_wr_data[CHARGE_W-1:0];
            REG_VIBRA_MIN:     cfg_in.vibra_min       = csr_wr_data[CHARGE_W-1:0];
            REG_VIBRA_MAX:     cfg_in.vibra_max       = csr_wr_data[CHARGE_W-1:0];
            REG_DEBOUNCE:      cfg_in.debounce_needed = csr_wr_data[DEB_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_delay   <= STARTUP_DELAY_RST;
         cfg_ff.poll_period     <= POLL_PERIOD_RST;
         cfg_ff.timeout         <= TIMEOUT_RST;
         cfg_ff.mmwave_min      <= MMWAVE_MIN_RST;
         cfg_ff.mmwave_max      <= MMWAVE_MAX_RST;
         cfg_ff.vibra_min       <= VIBRA_MIN_RST;
         cfg_ff.vibra_max       <= VIBRA_MAX_RST;
         cfg_ff.debounce_needed <= DEBOUNCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/rcts_poll.sv =====
module rcts_poll
   import rcts_pkg::*;
#(
   parameter int unsigned DISCHARGE_TICKS = DISCHARGE_TICKS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     level,
   input  cfg_type  cfg,
   output meas_type meas
);

   typedef enum logic [1:0] {
      PH_STARTUP,
      PH_IDLE,
      PH_DISCHARGE,
      PH_CHARGE
   } phase_type;

   localparam logic [CHARGE_W-1:0] DT = CHARGE_W'(DISCHARGE_TICKS);

   phase_type           phase_ff, phase_in;
   logic [PERIOD_W-1:0] period_ff, period_in, period_inc;
   logic [CHARGE_W-1:0] charge_ff, charge_in, charge_inc;
   logic                start;

   assign period_inc = (period_ff == {PERIOD_W{1'b1}}) ? period_ff : period_ff + 1'b1;
   assign charge_inc = charge_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      period_in = period_inc;
      charge_in = charge_ff;
      start     = 1'b0;
      meas      = '0;
      unique case (phase_ff)
         PH_STARTUP: begin
            if (period_ff >= cfg.startup_delay) begin
               start = 1'b1;
            end
         end
         PH_IDLE: begin
            if (period_inc >= cfg.poll_period) begin
               start = 1'b1;
            end
         end
         PH_DISCHARGE: begin
            meas.drive = 1'b1;
            if (charge_inc >= DT) begin
               phase_in  = PH_CHARGE;
               charge_in = '0;
            end else begin
               charge_in = charge_inc;
            end
         end
         PH_CHARGE: begin
            if (level) begin
               meas.done = 1'b1;
            end else if (charge_ff >= cfg.timeout) begin
               meas.done = 1'b1;
               meas.tmo  = 1'b1;
            end else begin
               charge_in = charge_inc;
            end
         end
         default: phase_in = PH_STARTUP;
      endcase
      meas.count = charge_ff;
      if (start) begin
         period_in  = '0;
         meas.drive = 1'b1;
         if (DT <= CHARGE_W'(1)) begin
            phase_in  = PH_CHARGE;
            charge_in = '0;
         end else begin
            phase_in  = PH_DISCHARGE;
            charge_in = CHARGE_W'(1);
         end
      end
      if (meas.done) begin
         phase_in  = PH_IDLE;
         charge_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STARTUP;
         period_ff <= '0;
         charge_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         period_ff <= period_in;
         charge_ff <= charge_in;
      end
   end

endmodule

// ===== hw/rtl/rcts_debounce.sv =====
module rcts_debounce
   import rcts_pkg::*;
#(
   parameter int unsigned COUNT_MAX = COUNT_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  cfg_type     cfg,
   input  meas_type    meas,
   output deb_res_type res
);

   localparam int unsigned EQ_W  = $clog2(COUNT_MAX + 1);
   localparam int unsigned EXT_W = (EQ_W > STABLE_W) ? EQ_W : STABLE_W;
   localparam logic [EQ_W-1:0] EQ_MAX = EQ_W'(COUNT_MAX);

   logic [CHARGE_W-1:0] measure_ff, measure_in;
   class_type           last_ff, last_in, cls, state_ff, state_in;
   logic [EQ_W-1:0]     eq_ff, eq_in;
   logic [EXT_W-1:0]    eq_ext;
   logic                changed;

   always_comb begin
      priority if (meas.tmo) begin
         cls = CLS_NONE;
      end else if (meas.count >= cfg.mmwave_min && meas.count <= cfg.mmwave_max) begin
         cls = CLS_MMWAVE;
      end else if (meas.count >= cfg.vibra_min && meas.count <= cfg.vibra_max) begin
         cls = CLS_VIBRA;
      end else begin
         cls = CLS_UNKNOWN;
      end
   end

   always_comb begin
      measure_in = measure_ff;
      last_in    = last_ff;
      eq_in      = eq_ff;
      state_in   = state_ff;
      changed    = 1'b0;
      if (meas.done) begin
         measure_in = meas.count;
         if (cls == last_ff) begin
            if (eq_ff < EQ_MAX) begin
               eq_in = eq_ff + 1'b1;
            end
         end else begin
            eq_in   = EQ_W'(1);
            last_in = cls;
         end
         if (EXT_W'(eq_in) >= EXT_W'(cfg.debounce_needed) && cls != state_ff) begin
            state_in = cls;
            changed  = 1'b1;
         end
      end
   end

   assign eq_ext = EXT_W'(eq_in);

   always_comb begin
      res.measured  = measure_in;
      res.det_class = last_in;
      res.stable    = (eq_ext > EXT_W'(255)) ? 8'd255 : eq_ext[STABLE_W-1:0];
      res.cur_state = state_in;
      res.changed   = changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measure_ff <= '0;
         last_ff    <= CLS_NONE;
         eq_ff      <= '0;
         state_ff   <= CLS_NONE;
      end else if (advance) begin
         measure_ff <= measure_in;
         last_ff    <= last_in;
         eq_ff      <= eq_in;
         state_ff   <= state_in;
      end
   end

endmodule
